### rtl/tlf_pkg.sv
// Shared types and constants for the text line folder.
// Holds the request, response and internal byte stream word types.
// No dependencies.
package tlf_pkg;

   // Character codes.
   localparam logic [7:0] CH_NEWLINE  = 8'd10;
   localparam logic [7:0] CH_SPACE    = 8'd32;

   // Control register reset values and limits.
   localparam logic [7:0] WIDTH_RESET = 8'd80;
   localparam logic [7:0] COLUMN_MAX  = 8'd255;

   // Control register port.
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINE_WIDTH      = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BREAK_AT_SPACES = 4'd1;

   // One input word.
   typedef struct packed {
      logic [7:0] in_char;
      logic       end_of_input;
   } req_word_type;

   // One output word: up to eight bytes, first byte in the low lane.
   typedef struct packed {
      logic [63:0] out_chars;
      logic [3:0]  out_count;
      logic        last_of_run;
   } rsp_word_type;

   // One byte on its way from the sequencer to the packer.
   typedef struct packed {
      logic       valid;
      logic       last;
      logic [7:0] data;
   } byte_stream_type;

endpackage

### rtl/text_line_folder.sv
// Text line folder: wraps a byte stream to a configured line width.
// Depends on tlf_pkg, tlf_line_ram, tlf_sequencer and tlf_packer.
//
// Usage: each req word carries one text byte or an end-of-input mark.
// Output bytes leave on the rsp channel packed up to eight per word, first
// byte in the low lane; last_of_run marks the final word caused by a req word.
// The csr port sets line_width (index 0) and break_at_spaces (index 1); write
// it only while the block is idle.
//
// Sequence: a plain-mode word is sent from the literal state, as its byte or,
// when a newline is inserted, as the newline and then the byte; its result is
// registered in the response register. In space mode a byte that does not
// fill the line gives no output. A break or newline streams the held bytes
// through the read port of the line store, one byte per cycle while the packer
// takes them, then the newline; after a break at a space, the kept text is
// copied to the start of the store. End of input drains the held bytes the
// same way, without a newline.
//
// Reset clears the line state, sets line_width to 80 and plain mode. The line
// store needs no clearing pass: only entries below the fill count are read.
// When the receiver stalls, the finished word holds in the output register
// and a word's final byte waits; a req word is taken once the sequencer is idle.
module text_line_folder #(
   parameter int BUFFER_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tlf_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tlf_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_write_en,
   input  logic [tlf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tlf_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import tlf_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);

   logic            ram_wr_en;
   logic [AW-1:0]   ram_wr_addr;
   logic [7:0]      ram_wr_data;
   logic            ram_rd_en;
   logic [AW-1:0]   ram_rd_addr;
   logic [7:0]      ram_rd_data;
   byte_stream_type byte_stream;
   logic            byte_ready;

   // Line store.
   tlf_line_ram #(.DEPTH(BUFFER_DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Control and line state.
   tlf_sequencer #(.DEPTH(BUFFER_DEPTH)) u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_word     (req_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .byte_out     (byte_stream),
      .byte_ready   (byte_ready)
   );

   // Output packing and response register.
   tlf_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .byte_in    (byte_stream),
      .byte_ready (byte_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule

### rtl/tlf_line_ram.sv
// Line store: byte-wide memory with one write and one read port.
// The read data is registered, so it shows in the cycle after the read enable.
// Depends on nothing.
module tlf_line_ram #(
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data register holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tlf_packer.sv
// Output packer: gathers bytes into words of up to eight and holds the
// finished word in the response register. Depends on tlf_pkg.
module tlf_packer (
   input  logic                     clock,
   input  logic                     reset,
   input  tlf_pkg::byte_stream_type byte_in,
   output logic                     byte_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tlf_pkg::rsp_word_type    rsp_word
);
   import tlf_pkg::*;

   logic [63:0]  acc_ff, acc_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic [63:0]  word_next;
   logic         completes;
   logic         out_free;
   logic         take;

   // Lanes below the count come from the accumulator, the current byte
   // lands in the next lane, and the lanes above it read as zero.
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         if (3'(k) < cnt_ff) begin
            word_next[k*8 +: 8] = acc_ff[k*8 +: 8];
         end else if (3'(k) == cnt_ff) begin
            word_next[k*8 +: 8] = byte_in.data;
         end else begin
            word_next[k*8 +: 8] = 8'h00;
         end
      end
   end

   assign completes  = (cnt_ff == 3'd7) || byte_in.last;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign byte_ready = !completes || out_free;
   assign take       = byte_in.valid && byte_ready;

   // Accumulate, or hand a full or final word to the response register.
   always_comb begin
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take) begin
         if (completes) begin
            cnt_in                  = 3'd0;
            rsp_valid_in            = 1'b1;
            rsp_word_in.out_chars   = word_next;
            rsp_word_in.out_count   = {1'b0, cnt_ff} + 4'd1;
            rsp_word_in.last_of_run = byte_in.last;
         end else begin
            acc_in[{cnt_ff, 3'b000} +: 8] = byte_in.data;
            cnt_in                        = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### rtl/tlf_sequencer.sv
// Sequencer: control registers, line state and the state machine that
// drains, breaks and compacts the line store. Depends on tlf_pkg.
module tlf_sequencer #(
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  tlf_pkg::req_word_type                  req_word,
   input  logic                                   csr_write_en,
   input  logic [tlf_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [tlf_pkg::CSR_DATA_WIDTH-1:0]     csr_data,
   output logic                                   ram_wr_en,
   output logic [AW-1:0]                          ram_wr_addr,
   output logic [7:0]                             ram_wr_data,
   output logic                                   ram_rd_en,
   output logic [AW-1:0]                          ram_rd_addr,
   input  logic [7:0]                             ram_rd_data,
   output tlf_pkg::byte_stream_type               byte_out,
   input  logic                                   byte_ready
);
   import tlf_pkg::*;

   localparam int CW = (AW > 8) ? AW : 8;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DRAIN = 4'b0010,
      ST_TAIL  = 4'b0100,
      ST_MOVE  = 4'b1000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   logic [7:0]    width_ff, width_in;
   logic          spaces_ff, spaces_in;
   logic [AW-1:0] fill_ff, fill_in;
   logic [AW-1:0] spos_ff, spos_in;
   logic          sseen_ff, sseen_in;
   logic [7:0]    col_ff, col_in;

   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [AW-1:0] rd_left_ff, rd_left_in;
   logic          pend_ff, pend_in;
   logic          pend_last_ff, pend_last_in;
   logic          add_nl_ff, add_nl_in;
   logic [7:0]    lit0_ff, lit0_in;
   logic [7:0]    lit1_ff, lit1_in;
   logic          lit_pair_ff, lit_pair_in;
   logic [AW-1:0] mv_src_ff, mv_src_in;
   logic [AW-1:0] mv_dst_ff, mv_dst_in;
   logic [AW-1:0] mv_left_ff, mv_left_in;
   logic          mv_pend_ff, mv_pend_in;

   // Decode of the incoming byte against the line state.
   logic          accept;
   logic          is_nl;
   logic          is_sp;
   logic          sseen_n;
   logic [AW-1:0] spos_n;
   logic          store_en;
   logic [AW-1:0] fill_n;
   logic          brk;
   logic          at_space;
   logic [AW-1:0] keep_n;
   logic          take;
   logic          issue;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_nl     = (req_word.in_char == CH_NEWLINE);
   assign is_sp     = (req_word.in_char == CH_SPACE);
   assign sseen_n   = sseen_ff || is_sp;
   assign spos_n    = is_sp ? fill_ff : spos_ff;
   assign store_en  = (fill_ff < AW'(DEPTH - 1));
   assign fill_n    = store_en ? fill_ff + AW'(1) : fill_ff;
   assign brk       = (CW'(fill_n) >= CW'(width_ff));
   assign at_space  = sseen_n && (spos_n < fill_n);
   assign keep_n    = fill_n - spos_n - AW'(1);

   assign take  = pend_ff && byte_ready;
   assign issue = (rd_left_ff != '0) && (!pend_ff || take);

   // Configuration writes.
   always_comb begin
      width_in  = width_ff;
      spaces_in = spaces_ff;
      if (csr_write_en) begin
         if (csr_index == CSR_LINE_WIDTH) begin
            width_in = csr_data;
         end else if (csr_index == CSR_BREAK_AT_SPACES) begin
            spaces_in = csr_data[0];
         end
      end
   end

   // Main state machine.
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      spos_in      = spos_ff;
      sseen_in     = sseen_ff;
      col_in       = col_ff;
      rd_addr_in   = rd_addr_ff;
      rd_left_in   = rd_left_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      add_nl_in    = add_nl_ff;
      lit0_in      = lit0_ff;
      lit1_in      = lit1_ff;
      lit_pair_in  = lit_pair_ff;
      mv_src_in    = mv_src_ff;
      mv_dst_in    = mv_dst_ff;
      mv_left_in   = mv_left_ff;
      mv_pend_in   = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = fill_ff;
      ram_wr_data  = req_word.in_char;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = rd_addr_ff;
      byte_out     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_addr_in  = '0;
               mv_dst_in   = '0;
               mv_left_in  = '0;
               lit0_in     = CH_NEWLINE;
               lit_pair_in = 1'b0;
               if (req_word.end_of_input) begin
                  // Flush the held line without a newline, then start over.
                  rd_left_in = fill_ff;
                  add_nl_in  = 1'b0;
                  fill_in    = '0;
                  spos_in    = '0;
                  sseen_in   = 1'b0;
                  col_in     = 8'd0;
                  state_in   = (fill_ff != '0) ? ST_DRAIN : ST_IDLE;
               end else if (!spaces_ff) begin
                  // Plain mode: one or two literal bytes.
                  if (is_nl) begin
                     col_in = 8'd0;
                  end else if (col_ff >= width_ff) begin
                     lit1_in     = req_word.in_char;
                     lit_pair_in = 1'b1;
                     col_in      = 8'd1;
                  end else begin
                     lit0_in = req_word.in_char;
                     col_in  = (col_ff < COLUMN_MAX) ? col_ff + 8'd1 : col_ff;
                  end
                  state_in = ST_TAIL;
               end else if (is_nl) begin
                  // Space mode newline: emit the held line and the newline.
                  rd_left_in = fill_ff;
                  add_nl_in  = 1'b1;
                  fill_in    = '0;
                  spos_in    = '0;
                  sseen_in   = 1'b0;
                  state_in   = (fill_ff != '0) ? ST_DRAIN : ST_TAIL;
               end else begin
                  // Space mode byte: store it, then break if the line is full.
                  ram_wr_en = store_en;
                  if (brk) begin
                     add_nl_in = 1'b1;
                     sseen_in  = 1'b0;
                     spos_in   = '0;
                     if (at_space) begin
                        rd_left_in = spos_n;
                        mv_left_in = keep_n;
                        mv_src_in  = spos_n + AW'(1);
                        fill_in    = keep_n;
                        state_in   = (spos_n != '0) ? ST_DRAIN : ST_TAIL;
                     end else begin
                        rd_left_in = fill_n;
                        fill_in    = '0;
                        state_in   = (fill_n != '0) ? ST_DRAIN : ST_TAIL;
                     end
                  end else begin
                     fill_in  = fill_n;
                     sseen_in = sseen_n;
                     spos_in  = spos_n;
                  end
               end
            end
         end

         ST_DRAIN: begin
            // Stream stored bytes; a read is issued only when its data
            // register is free or being taken.
            byte_out.valid = pend_ff;
            byte_out.last  = pend_last_ff;
            byte_out.data  = ram_rd_data;
            ram_rd_en      = issue;
            ram_rd_addr    = rd_addr_ff;
            pend_in        = issue || (pend_ff && !take);
            if (issue) begin
               rd_addr_in   = rd_addr_ff + AW'(1);
               rd_left_in   = rd_left_ff - AW'(1);
               pend_last_in = (rd_left_ff == AW'(1)) && !add_nl_ff;
            end
            if ((rd_left_ff == '0) && take) begin
               state_in = add_nl_ff ? ST_TAIL : ST_IDLE;
            end
         end

         ST_TAIL: begin
            // Literal bytes: a newline, a plain byte, or a newline and a byte.
            byte_out.valid = 1'b1;
            byte_out.last  = !lit_pair_ff;
            byte_out.data  = lit0_ff;
            if (byte_ready) begin
               if (lit_pair_ff) begin
                  lit0_in     = lit1_ff;
                  lit_pair_in = 1'b0;
               end else begin
                  state_in = (mv_left_ff != '0) ? ST_MOVE : ST_IDLE;
               end
            end
         end

         ST_MOVE: begin
            // Copy the text after the break down to the start of the store.
            // Reads run ahead of writes and never see a moved entry.
            ram_rd_en   = (mv_left_ff != '0);
            ram_rd_addr = mv_src_ff;
            mv_pend_in  = (mv_left_ff != '0);
            ram_wr_en   = mv_pend_ff;
            ram_wr_addr = mv_dst_ff;
            ram_wr_data = ram_rd_data;
            if (mv_left_ff != '0) begin
               mv_src_in  = mv_src_ff + AW'(1);
               mv_left_in = mv_left_ff - AW'(1);
            end
            if (mv_pend_ff) begin
               mv_dst_in = mv_dst_ff + AW'(1);
               if (mv_left_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= WIDTH_RESET;
         spaces_ff    <= 1'b0;
         fill_ff      <= '0;
         spos_ff      <= '0;
         sseen_ff     <= 1'b0;
         col_ff       <= 8'd0;
         rd_addr_ff   <= '0;
         rd_left_ff   <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         add_nl_ff    <= 1'b0;
         lit_pair_ff  <= 1'b0;
         mv_src_ff    <= '0;
         mv_dst_ff    <= '0;
         mv_left_ff   <= '0;
         mv_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         spaces_ff    <= spaces_in;
         fill_ff      <= fill_in;
         spos_ff      <= spos_in;
         sseen_ff     <= sseen_in;
         col_ff       <= col_in;
         rd_addr_ff   <= rd_addr_in;
         rd_left_ff   <= rd_left_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         add_nl_ff    <= add_nl_in;
         lit_pair_ff  <= lit_pair_in;
         mv_src_ff    <= mv_src_in;
         mv_dst_ff    <= mv_dst_in;
         mv_left_ff   <= mv_left_in;
         mv_pend_ff   <= mv_pend_in;
      end
   end

   // Literal bytes are payload and need no reset.
   always_ff @(posedge clock) begin
      lit0_ff <= lit0_in;
      lit1_ff <= lit1_in;
   end

endmodule

### rtl/tlf_checker.sv
// Port-level checks for the text line folder, attached by a bind.
// Depends on tlf_pkg and text_line_folder.
module tlf_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input tlf_pkg::rsp_word_type rsp_word
);
   import tlf_pkg::*;

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // Every response word carries one to eight bytes.
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.out_count >= 4'd1) && (rsp_word.out_count <= 4'd8))
      else $error("response byte count out of range");

   // Only the final word of a run may be short.
   a_short_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.out_count != 4'd8) |-> rsp_word.last_of_run)
      else $error("short response word is not last of run");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind text_line_folder tlf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
